FILE: rtl/core/dlfb_pkg.sv
// Shared types and constants for the dense layer forward and backward block.
`default_nettype none
package dlfb_pkg;
	localparam int MAX_OUTPUTS = 64;
	localparam int MAX_INPUTS  = 64;
	localparam int VALUE_BITS  = 16;
	localparam int ACC_BITS    = 40;
	localparam int ONE_Q_SHIFT = 8;
	localparam int OI_BITS     = 6;
	localparam int II_BITS     = 6;
	localparam int CNT_BITS    = 7;
	localparam int CFG_BITS    = 7;
	localparam logic [CNT_BITS-1:0] OUT_COUNT_RESET = 7'd10;
	localparam logic [CNT_BITS-1:0] IN_COUNT_RESET  = 7'd64;

	typedef enum logic [1:0] {
		OP_LOAD_WEIGHT = 2'd0,
		OP_LOAD_BIAS   = 2'd1,
		OP_FORWARD     = 2'd2,
		OP_GRADIENT    = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_OUT_COUNT = 1'b0,
		REG_IN_COUNT  = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]                   opcode;
		logic [OI_BITS-1:0]           out_index;
		logic [II_BITS-1:0]           in_index;
		logic signed [VALUE_BITS-1:0] value;
		logic                         last_in;
	} in_item_t;

	typedef struct packed {
		logic                         kind;
		logic [5:0]                   index;
		logic signed [15:0]           result_value;
		logic                         last_out;
	} out_item_t;

	function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] v,
			input logic [CNT_BITS-1:0] hi);
		logic [CNT_BITS-1:0] r;
		r = v;
		if (v == '0) r = CNT_BITS'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

	// floor(acc / 256) saturated to the value range
	function automatic logic [15:0] emit_value(input logic signed [ACC_BITS-1:0] acc);
		logic signed [ACC_BITS-ONE_Q_SHIFT-1:0] q;
		logic [15:0] r;
		q = acc[ACC_BITS-1:ONE_Q_SHIFT];
		if (q > (ACC_BITS-ONE_Q_SHIFT)'(32767)) r = 16'h7FFF;
		else if (q < -(ACC_BITS-ONE_Q_SHIFT)'(32768)) r = 16'h8000;
		else r = q[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/dense_layer_forward_backward.sv
// Top level of the dense layer forward and backward block.
// One request at a time. A forward element sweeps the active outputs, a gradient sweeps
// the active inputs: one multiply-accumulate per cycle from the weight memory, then a
// drain of the read pipe (stages 1 and 2) before the next request is accepted. A last
// item then waits in ST_EMIT_RD for the pipe to empty and emits count results through a
// one-entry output register: each entry is read, loaded the next cycle, and the next
// read issues only once the register has been taken. Accumulators lie in two 64-entry
// memories with a registered read; the run-start bias load and clear are folded into the
// first sweep of a run, and per-entry written flags make entries that were never written
// since reset read as zero.
`default_nettype none
module dense_layer_forward_backward import dlfb_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_item,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);
	localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;

	logic signed [VALUE_BITS-1:0] weight_mem [WDEPTH];
	logic signed [VALUE_BITS-1:0] bias_mem   [MAX_OUTPUTS];
	logic signed [ACC_BITS-1:0]   fwd_mem    [MAX_OUTPUTS];
	logic signed [ACC_BITS-1:0]   grad_mem   [MAX_INPUTS];
	logic [MAX_OUTPUTS-1:0]       fwd_vld_q;   // entry written since reset
	logic [MAX_INPUTS-1:0]        grad_vld_q;

	logic [CNT_BITS-1:0] out_count_q, in_count_q;
	logic fwd_run_q, bwd_run_q;
	state_t state_q, state_d;
	in_item_t item_q;
	logic [5:0] k_q;          // sweep index, read address in flight
	logic [CNT_BITS-1:0] n_q; // sweep length
	logic fresh_q;            // first item of a run: seed the entries

	// stage 1: memory read data
	logic rd_v_s1;
	logic [5:0] rd_k_s1;
	logic signed [VALUE_BITS-1:0] w_s1, b_s1;
	logic signed [ACC_BITS-1:0] acc_s1;
	logic vld_s1;
	logic signed [ACC_BITS-1:0] acc_rd;
	// stage 2: product
	logic rd_v_s2;
	logic [5:0] rd_k_s2;
	logic signed [ACC_BITS-1:0] base_s2;
	logic signed [2*VALUE_BITS-1:0] prod_s2;

	logic is_fwd;
	logic [CNT_BITS-1:0] no, ni;
	logic active;
	logic [5:0] rd_addr;
	logic [11:0] w_addr;
	logic issue, sweep_end;
	logic emit_go, emit_step;
	logic out_free;
	logic emit_rd_v_q;

	assign no = clamp_count(out_count_q, CNT_BITS'(MAX_OUTPUTS));
	assign ni = clamp_count(in_count_q, CNT_BITS'(MAX_INPUTS));
	assign is_fwd = (item_q.opcode == OP_FORWARD);
	// Forward adds only for in_index < ni; gradient only for out_index < no.
	assign active = is_fwd ? ({1'b0, item_q.in_index} < ni) : ({1'b0, item_q.out_index} < no);
	assign rd_addr = k_q;
	assign w_addr = is_fwd ? {k_q, item_q.in_index} : {item_q.out_index, k_q};
	assign issue = (state_q == ST_MAC);
	assign sweep_end = ({1'b0, k_q} == n_q - CNT_BITS'(1));
	assign out_free = !out_valid || out_ready;
	// hold the next read until the one in flight has landed in the output register
	assign emit_step = (state_q == ST_EMIT) && !emit_rd_v_q && out_free;
	assign in_ready = (state_q == ST_IDLE) && !rd_v_s1 && !rd_v_s2;
	assign emit_go = rd_v_s1 || rd_v_s2;
	// drop stale contents of entries never written since reset
	assign acc_rd = vld_s1 ? acc_s1 : '0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_count_q <= OUT_COUNT_RESET;
			in_count_q  <= IN_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_OUT_COUNT: out_count_q <= cfg_data;
				REG_IN_COUNT:  in_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready &&
						(in_item.opcode == OP_FORWARD || in_item.opcode == OP_GRADIENT))
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (sweep_end) state_d = item_q.last_in ? ST_EMIT_RD : ST_IDLE;
			end
			// drain the MAC pipe before reading for emission
			ST_EMIT_RD: begin
				if (!emit_go) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_step && sweep_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Item capture, sweep counter and run flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			n_q <= CNT_BITS'(1);
			fwd_run_q <= 1'b0;
			bwd_run_q <= 1'b0;
			fresh_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid && in_ready) begin
				k_q <= '0;
				if (in_item.opcode == OP_FORWARD) begin
					n_q <= no;
					fresh_q <= !fwd_run_q;
					fwd_run_q <= 1'b1;
				end else if (in_item.opcode == OP_GRADIENT) begin
					n_q <= ni;
					fresh_q <= !bwd_run_q;
					bwd_run_q <= 1'b1;
				end
			end else if (state_q == ST_MAC) begin
				k_q <= sweep_end ? '0 : k_q + 6'd1;
				if (sweep_end && item_q.last_in) begin
					// the emit uses the counts in force at the last item
					n_q <= is_fwd ? no : ni;
				end
			end else if (emit_step) begin
				k_q <= k_q + 6'd1;
				if (sweep_end) begin
					if (is_fwd) fwd_run_q <= 1'b0;
					else bwd_run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) item_q <= in_item;
	end

	// Weight and bias memories: write on loads, read during the sweep
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			if (in_item.opcode == OP_LOAD_WEIGHT)
				weight_mem[{in_item.out_index, in_item.in_index}] <= in_item.value;
			if (in_item.opcode == OP_LOAD_BIAS)
				bias_mem[in_item.out_index] <= in_item.value;
		end
		w_s1 <= weight_mem[w_addr];
		b_s1 <= bias_mem[rd_addr];
	end

	// Accumulator memories: read at k, written back from stage 2. The sweep never revisits
	// an entry while its write-back is in flight except across items of the same run, which
	// the drain in idle (in_ready waits for the pipe) keeps apart.
	logic [5:0] emit_addr;
	assign emit_addr = k_q;
	always_ff @(posedge clk) begin
		acc_s1 <= is_fwd ? fwd_mem[rd_addr] : grad_mem[rd_addr];
		vld_s1 <= is_fwd ? fwd_vld_q[rd_addr] : grad_vld_q[rd_addr];
		if (rd_v_s2) begin
			if (is_fwd) fwd_mem[rd_k_s2] <= base_s2 + ACC_BITS'(prod_s2);
			else grad_mem[rd_k_s2] <= base_s2 + ACC_BITS'(prod_s2);
		end
	end

	// Mark entries as written alongside the write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q  <= '0;
			grad_vld_q <= '0;
		end else if (rd_v_s2) begin
			if (is_fwd) fwd_vld_q[rd_k_s2] <= 1'b1;
			else grad_vld_q[rd_k_s2] <= 1'b1;
		end
	end

	logic seed_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			rd_v_s2 <= rd_v_s1;
		end
	end

	// MAC stage: seed from bias or zero at run start, then add the product
	always_ff @(posedge clk) begin
		rd_k_s1 <= k_q;
		seed_s1 <= fresh_q;
		rd_k_s2 <= rd_k_s1;
		if (seed_s1) base_s2 <= is_fwd ? (ACC_BITS'(b_s1) <<< ONE_Q_SHIFT) : '0;
		else base_s2 <= acc_rd;
		if (active) prod_s2 <= item_q.value * w_s1;
		else prod_s2 <= '0;
	end

	// Output register: load the entry read in the previous cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			emit_rd_v_q <= 1'b0;
		end else begin
			emit_rd_v_q <= emit_step;
			if (emit_rd_v_q) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	logic emit_last_q;
	logic [5:0] emit_k_q;
	always_ff @(posedge clk) begin
		emit_k_q <= emit_addr;
		emit_last_q <= sweep_end;
		if (emit_rd_v_q) begin
			out_item.kind <= !is_fwd;
			out_item.index <= emit_k_q;
			out_item.result_value <= emit_value(acc_rd);
			out_item.last_out <= emit_last_q;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item));
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_rd_v_q |-> !out_valid);
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !rd_v_s1 && !rd_v_s2);
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> ({1'b0, k_q} < n_q));
endmodule
`default_nettype wire

FILE: dv/dense_layer_forward_backward_test.sv
// Testbench for the dense layer forward and backward block: predicted results checked in order.
`default_nettype none
module dense_layer_forward_backward_test;
	import dlfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	dense_layer_forward_backward dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the layer state, kept by the predictor.
	logic signed [15:0] weight_mem [0:MAX_OUTPUTS*MAX_INPUTS-1];
	logic signed [15:0] bias_mem [0:MAX_OUTPUTS-1];
	logic signed [ACC_BITS-1:0] fwd_sum [0:MAX_OUTPUTS-1];
	logic signed [ACC_BITS-1:0] grad_sum [0:MAX_INPUTS-1];
	bit fwd_open, grad_open;
	int unsigned out_cnt_reg = 10, in_cnt_reg = 64;

	in_item_t pending_requests [$];
	out_item_t expected_results [$];
	int fail_count = 0;
	bit quiet = 1'b0;      // no idling near the end
	bit hold_off = 1'b0;   // long receiver stall
	int stall_left = 0, gap_left = 0;

	function automatic int unsigned active(int unsigned v);
		if (v == 0) return 1;
		return (v > 64) ? 64 : v;
	endfunction

	function automatic logic [15:0] saturate_q(logic signed [ACC_BITS-1:0] acc);
		logic signed [ACC_BITS-1:0] q;
		q = acc >>> 8;  // floor divide by 256
		if (q > 32767) return 16'h7FFF;
		if (q < -32768) return 16'h8000;
		return q[15:0];
	endfunction

	// Apply one accepted request to the shadow state and queue its results.
	task automatic predict_layer(in_item_t r);
		int unsigned no, ni, k;
		out_item_t o;
		no = active(out_cnt_reg);
		ni = active(in_cnt_reg);
		case (opcode_t'(r.opcode))
			OP_LOAD_WEIGHT: weight_mem[r.out_index*MAX_INPUTS + r.in_index] = r.value;
			OP_LOAD_BIAS: bias_mem[r.out_index] = r.value;
			OP_FORWARD: begin
				if (!fwd_open) begin
					for (k = 0; k < no; k++) fwd_sum[k] = ACC_BITS'(bias_mem[k]) <<< 8;
					fwd_open = 1'b1;
				end
				if (r.in_index < ni)
					for (k = 0; k < no; k++)
						fwd_sum[k] += ACC_BITS'(r.value) * ACC_BITS'(weight_mem[k*MAX_INPUTS + r.in_index]);
				if (r.last_in) begin
					for (k = 0; k < no; k++) begin
						o.kind = 1'b0; o.index = 6'(k); o.result_value = saturate_q(fwd_sum[k]);
						o.last_out = (k + 1 == no);
						expected_results.push_back(o);
					end
					fwd_open = 1'b0;
				end
			end
			OP_GRADIENT: begin
				if (!grad_open) begin
					for (k = 0; k < ni; k++) grad_sum[k] = '0;
					grad_open = 1'b1;
				end
				if (r.out_index < no)
					for (k = 0; k < ni; k++)
						grad_sum[k] += ACC_BITS'(r.value) * ACC_BITS'(weight_mem[r.out_index*MAX_INPUTS + k]);
				if (r.last_in) begin
					for (k = 0; k < ni; k++) begin
						o.kind = 1'b1; o.index = 6'(k); o.result_value = saturate_q(grad_sum[k]);
						o.last_out = (k + 1 == ni);
						expected_results.push_back(o);
					end
					grad_open = 1'b0;
				end
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		fail_count++;
	endtask

	// Driver: offer queued requests, predict on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_layer(in_item);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 15) == 0) begin
					gap_left <= $urandom_range(1, 18);
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					in_item <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result", 32'(out_item), '0);
				else begin
					w = expected_results.pop_front();
					if (out_item.kind !== w.kind)
						report_mismatch("kind", 32'(out_item.kind), 32'(w.kind));
					if (out_item.index !== w.index)
						report_mismatch("index", 32'(out_item.index), 32'(w.index));
					if (out_item.result_value !== w.result_value)
						report_mismatch("value", 32'(out_item.result_value), 32'(w.result_value));
					if (out_item.last_out !== w.last_out)
						report_mismatch("last", 32'(out_item.last_out), 32'(w.last_out));
				end
			end
			if (hold_off) out_ready <= 1'b0;
			else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(1, 18);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	function automatic in_item_t make_request(opcode_t op, int oi, int ii, int v, bit last);
		in_item_t r;
		r.opcode = op; r.out_index = 6'(oi); r.in_index = 6'(ii); r.value = 16'(v);
		r.last_in = last;
		return r;
	endfunction

	// Load every weight and bias that the current counts can read.
	task automatic queue_full_load(int unsigned no, int unsigned ni, bit extreme);
		int o, i, v;
		for (o = 0; o < no; o++) begin
			v = extreme ? 16'h7FFF : $urandom_range(0, 65535);
			pending_requests.push_back(make_request(OP_LOAD_BIAS, o, $urandom_range(0, 63), v,
				1'($urandom_range(0, 1))));
			for (i = 0; i < ni; i++) begin
				v = extreme ? ((o + i) % 2 ? 16'h8000 : 16'h7FFF) : $urandom_range(0, 65535);
				pending_requests.push_back(make_request(OP_LOAD_WEIGHT, o, i, v,
					1'($urandom_range(0, 1))));
			end
		end
	endtask

	// Load all biases, weight row 0 and weight column 0 of the full-size layer.
	task automatic queue_cross_load();
		int o, i;
		for (o = 0; o < MAX_OUTPUTS; o++)
			pending_requests.push_back(make_request(OP_LOAD_BIAS, o, 0,
				$urandom_range(0, 65535), 1'b0));
		for (i = 0; i < MAX_INPUTS; i++)
			pending_requests.push_back(make_request(OP_LOAD_WEIGHT, 0, i,
				$urandom_range(0, 65535), 1'b0));
		for (o = 1; o < MAX_OUTPUTS; o++)
			pending_requests.push_back(make_request(OP_LOAD_WEIGHT, o, 0,
				$urandom_range(0, 65535), 1'b0));
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int unsigned v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_BITS'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_OUT_COUNT) out_cnt_reg = v; else in_cnt_reg = v;
	endtask

	// Index up to hi, now and then one at or beyond the active count.
	function automatic int unsigned pick_index(int unsigned hi, int unsigned cnt);
		if (cnt < 64 && $urandom_range(0, 7) == 0) return $urandom_range(cnt, 63);
		return $urandom_range(0, hi);
	endfunction

	// Mixed runs with random content, mostly well formed; output indices mostly stay up to
	// oi_hi and input indices up to ii_hi.
	task automatic queue_runs(int n, int unsigned oi_hi, int unsigned ii_hi,
			int unsigned no, int unsigned ni);
		int k;
		opcode_t op;
		for (k = 0; k < n; k++) begin
			op = ($urandom_range(0, 1)) ? OP_FORWARD : OP_GRADIENT;
			pending_requests.push_back(make_request(op, pick_index(oi_hi, no),
				pick_index(ii_hi, ni), $urandom_range(0, 65535), $urandom_range(0, 5) == 0));
		end
		pending_requests.push_back(make_request(OP_FORWARD, 0, 0, 256, 1'b1));
		pending_requests.push_back(make_request(OP_GRADIENT, 0, 0, 256, 1'b1));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small layer at the extremes, every operation and out-of-range indices.
		write_reg(REG_OUT_COUNT, 2);
		write_reg(REG_IN_COUNT, 3);
		queue_full_load(2, 3, 1'b1);
		pending_requests.push_back(make_request(OP_FORWARD, 0, 0, 16'h7FFF, 1'b0));
		pending_requests.push_back(make_request(OP_FORWARD, 0, 63, 16'h7FFF, 1'b0));
		pending_requests.push_back(make_request(OP_FORWARD, 63, 2, 16'h8000, 1'b1));
		pending_requests.push_back(make_request(OP_GRADIENT, 1, 0, 16'h8000, 1'b0));
		pending_requests.push_back(make_request(OP_GRADIENT, 63, 0, 16'h7FFF, 1'b0));
		pending_requests.push_back(make_request(OP_GRADIENT, 0, 0, 16'h0001, 1'b1));
		pending_requests.push_back(make_request(OP_FORWARD, 0, 1, 16'hFFFF, 1'b1));
		drain();

		// Count of zero clamps to one; change counts mid-run.
		write_reg(REG_OUT_COUNT, 0);
		write_reg(REG_IN_COUNT, 0);
		pending_requests.push_back(make_request(OP_FORWARD, 0, 0, 16'h1234, 1'b0));
		pending_requests.push_back(make_request(OP_GRADIENT, 0, 0, 16'h4321, 1'b0));
		drain();
		write_reg(REG_OUT_COUNT, 2);
		write_reg(REG_IN_COUNT, 3);
		pending_requests.push_back(make_request(OP_FORWARD, 1, 2, 16'h0100, 1'b1));
		pending_requests.push_back(make_request(OP_GRADIENT, 1, 2, 16'h0100, 1'b1));
		drain();

		// Random, small sizes, with a long receiver hold-off.
		write_reg(REG_OUT_COUNT, 5);
		write_reg(REG_IN_COUNT, 7);
		queue_full_load(5, 7, 1'b0);
		queue_runs(30, 4, 6, 5, 7);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
		drain();

		// Largest sizes, over-range register values clamp to 64; runs stay on row 0 and
		// column 0.
		write_reg(REG_OUT_COUNT, 127);
		write_reg(REG_IN_COUNT, 64);
		queue_cross_load();
		queue_runs(10, 0, 0, 64, 64);
		drain();

		write_reg(REG_OUT_COUNT, 1);
		write_reg(REG_IN_COUNT, 64);
		queue_runs(15, 0, 63, 1, 64);
		drain();

		write_reg(REG_OUT_COUNT, 3);
		write_reg(REG_IN_COUNT, 2);
		quiet = 1'b1;
		pending_requests.push_back(make_request(OP_LOAD_WEIGHT, 1, 1,
			$urandom_range(0, 65535), 1'b0));
		pending_requests.push_back(make_request(OP_LOAD_WEIGHT, 2, 1,
			$urandom_range(0, 65535), 1'b0));
		queue_runs(15, 2, 1, 3, 2);
		drain();

		if (fail_count == 0)
			$display("** dense_layer_forward_backward: PASSED **");
		else
			$display("** dense_layer_forward_backward: FAILED **");
		$finish;
	end

	initial begin
		#40ms;
		$display("** dense_layer_forward_backward: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/dlfb_pkg.sv
rtl/core/dense_layer_forward_backward.sv
dv/dense_layer_forward_backward_test.sv
